// ----- design/assert_macros.svh -----
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define RBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- design/rbc_pkg.sv -----
// Package with types, codes and constants of the reconnect backoff controller.
`default_nettype none

package rbc_pkg;

	localparam int TAG_BITS_DEF   = 32;
	localparam int DELAY_BITS_DEF = 20;
	localparam int LIMIT_BITS     = 8;
	localparam int MODE_BITS      = 3;
	localparam int PHASE_BITS     = 3;
	localparam int CFG_IDX_BITS   = 2;

	// Values selected when a configuration register holds zero.
	localparam logic [LIMIT_BITS-1:0] DEF_LIMIT = 8'd3;
	localparam int DEF_FIRST = 250;
	localparam int DEF_CEIL  = 8000;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ATTEMPT_LIMIT = 2'd0,
		REG_FIRST_DELAY   = 2'd1,
		REG_DELAY_CEILING = 2'd2
	} cfg_reg_t;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_BEGIN    = 3'd0,
		MODE_FAILURE  = 3'd1,
		MODE_RETRY    = 3'd2,
		MODE_COMPLETE = 3'd3,
		MODE_CANCEL   = 3'd4
	} mode_t;

	typedef enum logic [PHASE_BITS-1:0] {
		PH_IDLE       = 3'd0,
		PH_ACTIVE     = 3'd1,
		PH_WAITING    = 3'd2,
		PH_ATTEMPTING = 3'd3,
		PH_TERMINAL   = 3'd4,
		PH_CANCELLED  = 3'd5
	} phase_t;

	typedef struct packed {
		logic accepted;
		logic retry_now;
		logic gave_up;
	} result_flags_t;

endpackage

`default_nettype wire

// ----- design/rbc_if.sv -----
// Channel interfaces: event input, result output and configuration write.
`default_nettype none

interface rbc_evt_if #(
	parameter int TAG_BITS = rbc_pkg::TAG_BITS_DEF
);
	logic                           valid;
	logic                           ready;
	logic [rbc_pkg::MODE_BITS-1:0]  mode;
	logic [TAG_BITS-1:0]            session_tag;
	logic                           retryable;
	logic                           success;

	modport source (output valid, mode, session_tag, retryable, success, input ready);
	modport sink (input valid, mode, session_tag, retryable, success, output ready);
endinterface

interface rbc_res_if #(
	parameter int TAG_BITS   = rbc_pkg::TAG_BITS_DEF,
	parameter int DELAY_BITS = rbc_pkg::DELAY_BITS_DEF
);
	logic                            valid;
	logic                            ready;
	logic                            accepted;
	logic                            retry_now;
	logic                            gave_up;
	logic [rbc_pkg::LIMIT_BITS-1:0]  attempt_number;
	logic [DELAY_BITS-1:0]           backoff_ms;
	logic [TAG_BITS-1:0]             echo_tag;
	logic [rbc_pkg::PHASE_BITS-1:0]  phase_now;

	modport source (output valid, accepted, retry_now, gave_up, attempt_number, backoff_ms,
		echo_tag, phase_now, input ready);
	modport sink (input valid, accepted, retry_now, gave_up, attempt_number, backoff_ms,
		echo_tag, phase_now, output ready);
endinterface

interface rbc_cfg_if #(
	parameter int DATA_BITS = rbc_pkg::DELAY_BITS_DEF
);
	logic                             valid;
	logic                             ready;
	logic [rbc_pkg::CFG_IDX_BITS-1:0] index;
	logic [DATA_BITS-1:0]             data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/rbc_cfg.sv -----
// Configuration registers and the effective limit, first delay and ceiling.
`default_nettype none

module rbc_cfg #(
	parameter int DELAY_BITS = rbc_pkg::DELAY_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [rbc_pkg::CFG_IDX_BITS-1:0] wr_index,
	input  wire logic [DELAY_BITS-1:0]           wr_data,
	output logic [rbc_pkg::LIMIT_BITS-1:0]       limit,
	output logic [DELAY_BITS-1:0]                first,
	output logic [DELAY_BITS-1:0]                ceil
);

	logic [rbc_pkg::LIMIT_BITS-1:0] limit_q;
	logic [DELAY_BITS-1:0]          first_q;
	logic [DELAY_BITS-1:0]          ceil_q;
	logic [DELAY_BITS-1:0]          ceil_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
			first_q <= '0;
			ceil_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				rbc_pkg::REG_ATTEMPT_LIMIT: limit_q <= wr_data[rbc_pkg::LIMIT_BITS-1:0];
				rbc_pkg::REG_FIRST_DELAY:   first_q <= wr_data;
				rbc_pkg::REG_DELAY_CEILING: ceil_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// A zero register selects its default; the ceiling never sits below the first delay.
	assign limit    = (limit_q != '0) ? limit_q : rbc_pkg::DEF_LIMIT;
	assign first    = (first_q != '0) ? first_q : DELAY_BITS'(rbc_pkg::DEF_FIRST);
	assign ceil_raw = (ceil_q != '0) ? ceil_q : DELAY_BITS'(rbc_pkg::DEF_CEIL);
	assign ceil     = (ceil_raw < first) ? first : ceil_raw;

endmodule

`default_nettype wire

// ----- design/rbc_engine.sv -----
// Session state registers and the per-event transition and result logic.
`default_nettype none

module rbc_engine #(
	parameter int TAG_BITS   = rbc_pkg::TAG_BITS_DEF,
	parameter int DELAY_BITS = rbc_pkg::DELAY_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           fire,
	input  wire logic [rbc_pkg::MODE_BITS-1:0]  mode,
	input  wire logic [TAG_BITS-1:0]            tag,
	input  wire logic                           retryable,
	input  wire logic                           success,
	input  wire logic [rbc_pkg::LIMIT_BITS-1:0] limit,
	input  wire logic [DELAY_BITS-1:0]          first,
	input  wire logic [DELAY_BITS-1:0]          ceil,
	output rbc_pkg::result_flags_t              flags,
	output logic [rbc_pkg::LIMIT_BITS-1:0]      attempt,
	output logic [DELAY_BITS-1:0]               delay,
	output rbc_pkg::phase_t                     phase_next
);

	rbc_pkg::phase_t                phase_q;
	logic [TAG_BITS-1:0]            tag_q;
	logic [rbc_pkg::LIMIT_BITS-1:0] count_q;
	logic [DELAY_BITS-1:0]          delay_q;

	logic [TAG_BITS-1:0]            tag_d;
	logic [rbc_pkg::LIMIT_BITS-1:0] count_d;
	logic [DELAY_BITS-1:0]          delay_d;

	logic                           tag_ok;
	logic [DELAY_BITS-1:0]          grown;
	logic [DELAY_BITS-1:0]          grown_cap;

	assign tag_ok = (tag != '0) && (tag == tag_q);

	// Doubling saturates at the ceiling; the first retry starts at the first delay.
	assign grown = (count_q == '0) ? first :
		(delay_q > (ceil >> 1)) ? ceil : {delay_q[DELAY_BITS-2:0], 1'b0};
	assign grown_cap = (grown > ceil) ? ceil : grown;

	always_comb begin
		phase_next = phase_q;
		tag_d      = tag_q;
		count_d    = count_q;
		delay_d    = delay_q;
		flags      = '0;
		attempt    = '0;
		delay      = '0;
		case (mode)
			rbc_pkg::MODE_BEGIN: begin
				if (tag != '0 && tag != tag_q && phase_q != rbc_pkg::PH_ACTIVE &&
					phase_q != rbc_pkg::PH_WAITING &&
					phase_q != rbc_pkg::PH_ATTEMPTING) begin
					tag_d          = tag;
					count_d        = '0;
					delay_d        = '0;
					phase_next     = rbc_pkg::PH_ACTIVE;
					flags.accepted = 1'b1;
				end
			end
			rbc_pkg::MODE_FAILURE: begin
				if (tag_ok && (phase_q == rbc_pkg::PH_ACTIVE ||
					phase_q == rbc_pkg::PH_ATTEMPTING)) begin
					flags.accepted = 1'b1;
					if (!retryable || count_q >= limit) begin
						phase_next    = rbc_pkg::PH_TERMINAL;
						delay_d       = '0;
						flags.gave_up = 1'b1;
						attempt       = count_q;
					end else begin
						count_d         = count_q + 1'b1;
						delay_d         = grown_cap;
						flags.retry_now = 1'b1;
						attempt         = count_q + 1'b1;
						delay           = grown_cap;
						phase_next      = rbc_pkg::PH_WAITING;
					end
				end
			end
			rbc_pkg::MODE_RETRY: begin
				if (tag_ok && phase_q == rbc_pkg::PH_WAITING) begin
					phase_next     = rbc_pkg::PH_ATTEMPTING;
					flags.accepted = 1'b1;
				end
			end
			rbc_pkg::MODE_COMPLETE: begin
				if (tag_ok && phase_q == rbc_pkg::PH_ATTEMPTING && success) begin
					phase_next     = rbc_pkg::PH_ACTIVE;
					count_d        = '0;
					delay_d        = '0;
					flags.accepted = 1'b1;
				end
			end
			rbc_pkg::MODE_CANCEL: begin
				if (tag_ok && (phase_q == rbc_pkg::PH_ACTIVE ||
					phase_q == rbc_pkg::PH_WAITING ||
					phase_q == rbc_pkg::PH_ATTEMPTING)) begin
					phase_next     = rbc_pkg::PH_CANCELLED;
					delay_d        = '0;
					flags.accepted = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rbc_pkg::PH_IDLE;
			tag_q   <= '0;
			count_q <= '0;
			delay_q <= '0;
		end else if (fire) begin
			phase_q <= phase_next;
			tag_q   <= tag_d;
			count_q <= count_d;
			delay_q <= delay_d;
		end
	end

endmodule

`default_nettype wire

// ----- design/reconnect_backoff_controller_core.sv -----
// Top level of the reconnect backoff controller: channels, stage registers and units.
//
//   Channel  Direction  Carries
//   evt      in         mode, session_tag, retryable, success
//   res      out        accepted, retry_now, gave_up, attempt_number, backoff_ms,
//                       echo_tag, phase_now
//   cfg      in         index, data (attempt_limit, first_delay, delay_ceiling)
//
// One event can be accepted in every cycle, as long as the result side is not stalled.
// An event is held in the input stage register; the transition logic updates the
// session state and loads the result register as the event moves on, and the result
// is offered from there. A stalled result holds the result register and then the
// input stage; the input stage still takes a transaction while a result waits, as
// long as it is itself empty. Reset clears the session to idle and all configuration
// registers to zero; configuration writes are always taken.
`default_nettype none

module reconnect_backoff_controller_core #(
	parameter int TAG_BITS   = rbc_pkg::TAG_BITS_DEF,
	parameter int DELAY_BITS = rbc_pkg::DELAY_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	rbc_evt_if.sink  evt,
	rbc_res_if.source res,
	rbc_cfg_if.sink  cfg
);

	// Input stage registers.
	logic                           s1_valid_q;
	logic [rbc_pkg::MODE_BITS-1:0]  mode_s1;
	logic [TAG_BITS-1:0]            tag_s1;
	logic                           retryable_s1;
	logic                           success_s1;

	// Result register.
	logic                           res_valid_q;
	rbc_pkg::result_flags_t         flags_q;
	logic [rbc_pkg::LIMIT_BITS-1:0] attempt_q;
	logic [DELAY_BITS-1:0]          delay_q;
	logic [TAG_BITS-1:0]            echo_q;
	rbc_pkg::phase_t                phase_q;

	// Effective configuration and engine outputs.
	logic [rbc_pkg::LIMIT_BITS-1:0] limit;
	logic [DELAY_BITS-1:0]          first;
	logic [DELAY_BITS-1:0]          ceil;
	rbc_pkg::result_flags_t         flags;
	logic [rbc_pkg::LIMIT_BITS-1:0] attempt;
	logic [DELAY_BITS-1:0]          delay;
	rbc_pkg::phase_t                phase_next;

	logic out_free;
	logic s1_fire;
	logic evt_take;

	// The result register can take a new result when it is empty or being drained.
	assign out_free  = !res_valid_q || res.ready;
	assign s1_fire   = s1_valid_q && out_free;
	assign evt.ready = !s1_valid_q || out_free;
	assign evt_take  = evt.valid && evt.ready;

	// Configuration writes never stall.
	assign cfg.ready = 1'b1;

	rbc_cfg #(
		.DELAY_BITS(DELAY_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid && cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.limit    (limit),
		.first    (first),
		.ceil     (ceil)
	);

	// The engine commits its state change only when the event moves on to the result.
	rbc_engine #(
		.TAG_BITS   (TAG_BITS),
		.DELAY_BITS (DELAY_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (s1_fire),
		.mode       (mode_s1),
		.tag        (tag_s1),
		.retryable  (retryable_s1),
		.success    (success_s1),
		.limit      (limit),
		.first      (first),
		.ceil       (ceil),
		.flags      (flags),
		.attempt    (attempt),
		.delay      (delay),
		.phase_next (phase_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (evt_take) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_take) begin
			mode_s1      <= evt.mode;
			tag_s1       <= evt.session_tag;
			retryable_s1 <= evt.retryable;
			success_s1   <= evt.success;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			flags_q   <= flags;
			attempt_q <= attempt;
			delay_q   <= delay;
			echo_q    <= tag_s1;
			phase_q   <= phase_next;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.accepted       = flags_q.accepted;
	assign res.retry_now      = flags_q.retry_now;
	assign res.gave_up        = flags_q.gave_up;
	assign res.attempt_number = attempt_q;
	assign res.backoff_ms     = delay_q;
	assign res.echo_tag       = echo_q;
	assign res.phase_now      = phase_q;

endmodule

`default_nettype wire

// ----- design/rbc_checker.sv -----
// Port-level checker for the reconnect backoff controller, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module rbc_checker #(
	parameter int TAG_BITS   = rbc_pkg::TAG_BITS_DEF,
	parameter int DELAY_BITS = rbc_pkg::DELAY_BITS_DEF
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           res_valid,
	input wire logic                           res_ready,
	input wire logic                           accepted,
	input wire logic                           retry_now,
	input wire logic                           gave_up,
	input wire logic [rbc_pkg::LIMIT_BITS-1:0] attempt_number,
	input wire logic [DELAY_BITS-1:0]          backoff_ms,
	input wire logic [TAG_BITS-1:0]            echo_tag,
	input wire logic [rbc_pkg::PHASE_BITS-1:0] phase_now
);

	logic                                                           res_stall;
	logic [rbc_pkg::LIMIT_BITS+DELAY_BITS+TAG_BITS+rbc_pkg::PHASE_BITS+2:0] res_word;
	logic                                                           retry_ok;
	logic                                                           gave_up_ok;
	logic                                                           quiet_ok;

	assign res_stall = res_valid && !res_ready;
	assign res_word  = {accepted, retry_now, gave_up, attempt_number, backoff_ms, echo_tag,
		phase_now};
	assign retry_ok  = accepted && !gave_up && phase_now == rbc_pkg::PH_WAITING &&
		backoff_ms != '0 && attempt_number != '0;
	assign gave_up_ok = accepted && !retry_now && phase_now == rbc_pkg::PH_TERMINAL &&
		backoff_ms == '0;
	assign quiet_ok  = !retry_now && !gave_up && attempt_number == '0 && backoff_ms == '0;

	// A stalled result stays put.
	`RBC_ASSERT_NXT(a_res_hold, clk, arst_n, res_stall, res_valid && $stable(res_word))

	// A scheduled retry is an accepted failure that leaves the session waiting.
	`RBC_ASSERT_IMP(a_retry_shape, clk, arst_n, res_valid && retry_now, retry_ok)

	// Giving up lands in terminal with no delay.
	`RBC_ASSERT_IMP(a_gave_up_shape, clk, arst_n, res_valid && gave_up, gave_up_ok)

	// An ignored event reports nothing but its tag and the phase.
	`RBC_ASSERT_IMP(a_ignored_quiet, clk, arst_n, res_valid && !accepted, quiet_ok)

endmodule

bind reconnect_backoff_controller_core rbc_checker #(
	.TAG_BITS   (TAG_BITS),
	.DELAY_BITS (DELAY_BITS)
) u_rbc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.accepted       (res.accepted),
	.retry_now      (res.retry_now),
	.gave_up        (res.gave_up),
	.attempt_number (res.attempt_number),
	.backoff_ms     (res.backoff_ms),
	.echo_tag       (res.echo_tag),
	.phase_now      (res.phase_now)
);

`default_nettype wire

// ----- dv/rbc_scoreboard_pkg.sv -----
// Scoreboard package: transaction types and the session predictor for the controller testbench.
package rbc_scoreboard_pkg;

	import rbc_pkg::*;

	typedef struct packed {
		logic [MODE_BITS-1:0]      mode;
		logic [TAG_BITS_DEF-1:0]   tag;
		logic                      retryable;
		logic                      success;
	} session_event_t;

	typedef struct packed {
		logic                      accepted;
		logic                      retry_now;
		logic                      gave_up;
		logic [LIMIT_BITS-1:0]     attempt_number;
		logic [DELAY_BITS_DEF-1:0] backoff_ms;
		logic [TAG_BITS_DEF-1:0]   echo_tag;
		logic [PHASE_BITS-1:0]     phase_now;
	} session_result_t;

	class session_scoreboard;
		// Configuration registers as written, zero meaning default.
		logic [LIMIT_BITS-1:0]     limit_reg;
		logic [DELAY_BITS_DEF-1:0] first_reg;
		logic [DELAY_BITS_DEF-1:0] ceiling_reg;

		// Predicted session state after every accepted event.
		phase_t                    phase;
		logic [TAG_BITS_DEF-1:0]   cur_tag;
		logic [LIMIT_BITS-1:0]     attempts;
		logic [DELAY_BITS_DEF-1:0] last_delay;

		session_result_t           expected_results[$];
		int unsigned               errors;

		function new();
			limit_reg   = '0;
			first_reg   = '0;
			ceiling_reg = '0;
			phase       = PH_IDLE;
			cur_tag     = '0;
			attempts    = '0;
			last_delay  = '0;
			errors      = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [DELAY_BITS_DEF-1:0] value);
			case (idx)
				REG_ATTEMPT_LIMIT: limit_reg = value[LIMIT_BITS-1:0];
				REG_FIRST_DELAY:   first_reg = value;
				REG_DELAY_CEILING: ceiling_reg = value;
				default: ;
			endcase
		endfunction

		// Applies one event taken by the block to the predicted state and queues its result.
		function void note_event(session_event_t ev);
			int unsigned     lim;
			int unsigned     first;
			int unsigned     ceiling;
			int unsigned     next_delay;
			bit              tag_ok;
			session_result_t r;
			lim = (limit_reg != 0) ? limit_reg : DEF_LIMIT;
			first = (first_reg != 0) ? first_reg : DEF_FIRST;
			ceiling = (ceiling_reg != 0) ? ceiling_reg : DEF_CEIL;
			if (ceiling < first)
				ceiling = first;
			tag_ok = (ev.tag != 0) && (ev.tag == cur_tag);
			r = '0;
			r.echo_tag = ev.tag;
			case (ev.mode)
				MODE_BEGIN: begin
					if (ev.tag != 0 && ev.tag != cur_tag &&
							!(phase inside {PH_ACTIVE, PH_WAITING, PH_ATTEMPTING})) begin
						cur_tag = ev.tag;
						attempts = '0;
						last_delay = '0;
						phase = PH_ACTIVE;
						r.accepted = 1'b1;
					end
				end
				MODE_FAILURE: begin
					if (tag_ok && (phase == PH_ACTIVE || phase == PH_ATTEMPTING)) begin
						r.accepted = 1'b1;
						if (!ev.retryable || attempts >= lim) begin
							phase = PH_TERMINAL;
							last_delay = '0;
							r.gave_up = 1'b1;
							r.attempt_number = attempts;
						end else begin
							attempts = attempts + 1'b1;
							if (attempts == 1)
								next_delay = first;
							else if (last_delay > ceiling / 2)
								next_delay = ceiling;
							else
								next_delay = last_delay * 2;
							if (next_delay > ceiling)
								next_delay = ceiling;
							last_delay = next_delay;
							phase = PH_WAITING;
							r.retry_now = 1'b1;
							r.attempt_number = attempts;
							r.backoff_ms = last_delay;
						end
					end
				end
				MODE_RETRY: begin
					if (tag_ok && phase == PH_WAITING) begin
						phase = PH_ATTEMPTING;
						r.accepted = 1'b1;
					end
				end
				MODE_COMPLETE: begin
					if (tag_ok && phase == PH_ATTEMPTING && ev.success) begin
						phase = PH_ACTIVE;
						attempts = '0;
						last_delay = '0;
						r.accepted = 1'b1;
					end
				end
				MODE_CANCEL: begin
					if (tag_ok && (phase inside {PH_ACTIVE, PH_WAITING, PH_ATTEMPTING})) begin
						phase = PH_CANCELLED;
						last_delay = '0;
						r.accepted = 1'b1;
					end
				end
				default: ;
			endcase
			r.phase_now = phase;
			expected_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		// Compares one result transaction with the oldest outstanding prediction.
		function void check_result(session_result_t got);
			session_result_t want;
			if (expected_results.size() == 0) begin
				$error("result with no outstanding event: echo_tag 0x%0h", got.echo_tag);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			compare_field("accepted", want.accepted, got.accepted);
			compare_field("retry_now", want.retry_now, got.retry_now);
			compare_field("gave_up", want.gave_up, got.gave_up);
			compare_field("attempt_number", want.attempt_number, got.attempt_number);
			compare_field("backoff_ms", want.backoff_ms, got.backoff_ms);
			compare_field("echo_tag", want.echo_tag, got.echo_tag);
			compare_field("phase_now", want.phase_now, got.phase_now);
		endfunction
	endclass

endpackage

// ----- dv/reconnect_backoff_controller_core_tb.sv -----
// Testbench top: drives session events and configuration, checks every result transaction.
module reconnect_backoff_controller_core_tb;

	import rbc_pkg::*;
	import rbc_scoreboard_pkg::*;

	localparam int CLK_HALF         = 4;
	localparam int RESET_CYCLES     = 3;
	localparam int PHASE_COUNT      = 7;
	localparam int ITEMS_PER_PHASE  = 190;
	// Idle cycles after the last predicted result has been checked.
	localparam int DRAIN_CYCLES     = 8;
	localparam int HOLD_CYCLES      = 300;
	// The phase in which the receiver holds off while events keep coming.
	localparam int HOLD_PHASE       = 5;
	// Longest legal quiet stretch is the receiver hold-off; this is many times that.
	localparam int WATCHDOG_LIMIT   = 5000;

	// Mode codes that the block does not define; they must be ignored.
	localparam logic [MODE_BITS-1:0] MODE_SPARE_FIRST = 3'd5;
	localparam logic [MODE_BITS-1:0] MODE_SPARE_LAST  = 3'd7;

	localparam logic [TAG_BITS_DEF-1:0]   TAG_ALL_ONES   = '1;
	localparam logic [DELAY_BITS_DEF-1:0] DELAY_ALL_ONES = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #CLK_HALF clk = ~clk;

	rbc_evt_if evt_bus ();
	rbc_res_if res_bus ();
	rbc_cfg_if cfg_bus ();

	reconnect_backoff_controller_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_bus),
		.res    (res_bus),
		.cfg    (cfg_bus)
	);

	session_scoreboard sb = new();

	// Shared between the processes: whether idle gaps are drawn in the current phase,
	// and a one-shot request for the receiver to hold off for a long stretch.
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;

	// Gap length for either side: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int roll;
		if (!idle_on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic session_event_t make_event(logic [MODE_BITS-1:0] mode,
			logic [TAG_BITS_DEF-1:0] tag, logic retryable, logic success);
		session_event_t ev;
		ev.mode = mode;
		ev.tag = tag;
		ev.retryable = retryable;
		ev.success = success;
		return ev;
	endfunction

	// Picks the next event from the predicted phase so that most traffic walks the
	// real session life cycle: begin, failures, retries, attempts, completion or cancel.
	// A small share is noise: any mode, with the current tag, a random tag or zero.
	// success_pct sets how often an attempt succeeds; a low value builds long
	// failure chains that reach the attempt limit and the delay ceiling.
	function automatic session_event_t next_session_event(int success_pct);
		session_event_t ev;
		int roll;
		int pick;
		ev = make_event(MODE_BEGIN, sb.cur_tag, $urandom_range(0, 1), $urandom_range(0, 1));
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			ev.mode = $urandom_range(0, 7);
			pick = $urandom_range(0, 3);
			if (pick == 0)
				ev.tag = '0;
			else if (pick == 1)
				ev.tag = $urandom;
			return ev;
		end
		pick = $urandom_range(0, 99);
		case (sb.phase)
			PH_ACTIVE: begin
				ev.mode = (pick < 97) ? MODE_FAILURE : MODE_CANCEL;
				ev.retryable = ($urandom_range(0, 99) < 92);
			end
			PH_WAITING: begin
				ev.mode = (pick < 98) ? MODE_RETRY : MODE_CANCEL;
			end
			PH_ATTEMPTING: begin
				if (pick < success_pct) begin
					ev.mode = MODE_COMPLETE;
					ev.success = 1'b1;
				end else if (pick < 90) begin
					ev.mode = MODE_FAILURE;
					ev.retryable = ($urandom_range(0, 99) < 95);
				end else if (pick < 97) begin
					ev.mode = MODE_COMPLETE;
					ev.success = 1'b0;
				end else begin
					ev.mode = MODE_CANCEL;
				end
			end
			default: begin
				// Idle, terminal or cancelled: open a new session. Small tags come
				// back often enough that a begin with the stored tag gets refused.
				ev.mode = MODE_BEGIN;
				ev.tag = ($urandom_range(0, 9) == 0) ? TAG_BITS_DEF'($urandom_range(1, 4))
					: TAG_BITS_DEF'($urandom);
			end
		endcase
		return ev;
	endfunction

	// Offers one event after a random gap and returns at the falling edge after the
	// transaction. Valid stays high on return, so back-to-back events never lower and
	// raise it in the same time step.
	task automatic send_event(input session_event_t ev);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			evt_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		evt_bus.valid <= 1'b1;
		evt_bus.mode <= ev.mode;
		evt_bus.session_tag <= ev.tag;
		evt_bus.retryable <= ev.retryable;
		evt_bus.success <= ev.success;
		do
			@(posedge clk);
		while (!evt_bus.ready);
		sb.note_event(ev);
		@(negedge clk);
	endtask

	// Stops offering events, waits until every predicted result has been checked and
	// then lets the pipeline run empty before it returns.
	task automatic settle_pipeline();
		evt_bus.valid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Writes all three registers back to back while the block is idle.
	task automatic configure(input logic [LIMIT_BITS-1:0] lim,
			input logic [DELAY_BITS_DEF-1:0] first, input logic [DELAY_BITS_DEF-1:0] ceiling);
		cfg_reg_t regs[3] = '{REG_ATTEMPT_LIMIT, REG_FIRST_DELAY, REG_DELAY_CEILING};
		logic [DELAY_BITS_DEF-1:0] values[3];
		values[0] = DELAY_BITS_DEF'(lim);
		values[1] = first;
		values[2] = ceiling;
		settle_pipeline();
		for (int i = 0; i < 3; i++) begin
			cfg_bus.valid <= 1'b1;
			cfg_bus.index <= regs[i];
			cfg_bus.data <= values[i];
			do
				@(posedge clk);
			while (!cfg_bus.ready);
			sb.write_reg(regs[i], values[i]);
			@(negedge clk);
		end
		cfg_bus.valid <= 1'b0;
	endtask

	// Result side: ready changes at the falling edge, transactions are taken at the
	// rising edge. The long hold-off is counted here, in this process's own cycles,
	// while the sender keeps offering events so the block fills and stalls its input.
	initial begin : result_sink
		int stall_left;
		int hold_left;
		bit rdy;
		session_result_t seen;
		stall_left = 0;
		hold_left = 0;
		res_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				rdy = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else begin
				stall_left = pick_gap();
				rdy = (stall_left == 0);
				if (!rdy)
					stall_left--;
			end
			res_bus.ready <= rdy;
			@(posedge clk);
			if (res_bus.valid && res_bus.ready) begin
				seen.accepted = res_bus.accepted;
				seen.retry_now = res_bus.retry_now;
				seen.gave_up = res_bus.gave_up;
				seen.attempt_number = res_bus.attempt_number;
				seen.backoff_ms = res_bus.backoff_ms;
				seen.echo_tag = res_bus.echo_tag;
				seen.phase_now = res_bus.phase_now;
				sb.check_result(seen);
			end
		end
	end

	// Watchdog: ends the run if no transaction happens on any channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((evt_bus.valid && evt_bus.ready) || (res_bus.valid && res_bus.ready) ||
					(cfg_bus.valid && cfg_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		logic [LIMIT_BITS-1:0]     lim;
		logic [DELAY_BITS_DEF-1:0] first;
		logic [DELAY_BITS_DEF-1:0] ceiling;
		int                        success_pct;
		evt_bus.valid = 1'b0;
		evt_bus.mode = MODE_BEGIN;
		evt_bus.session_tag = '0;
		evt_bus.retryable = 1'b0;
		evt_bus.success = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_ATTEMPT_LIMIT;
		cfg_bus.data = '0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part with the default settings (all registers zero, so the limit is
		// three and the delays run 250, 500, 1000). It walks every event type, the
		// refusal rules of begin, the ignored failed attempt, the limit, the
		// non-retryable failure, cancel, and the undefined mode codes.
		configure('0, '0, '0);
		send_event(make_event(MODE_BEGIN, '0, 1'b0, 1'b0));
		send_event(make_event(MODE_FAILURE, '0, 1'b1, 1'b0));
		send_event(make_event(MODE_BEGIN, TAG_ALL_ONES, 1'b0, 1'b0));
		send_event(make_event(MODE_BEGIN, 32'd5, 1'b0, 1'b0));
		send_event(make_event(MODE_FAILURE, 32'h1234, 1'b1, 1'b0));
		send_event(make_event(MODE_FAILURE, TAG_ALL_ONES, 1'b1, 1'b1));
		send_event(make_event(MODE_FAILURE, TAG_ALL_ONES, 1'b1, 1'b0));
		send_event(make_event(MODE_COMPLETE, TAG_ALL_ONES, 1'b0, 1'b1));
		send_event(make_event(MODE_RETRY, TAG_ALL_ONES, 1'b0, 1'b0));
		send_event(make_event(MODE_COMPLETE, TAG_ALL_ONES, 1'b1, 1'b0));
		for (int i = 0; i < 2; i++) begin
			send_event(make_event(MODE_FAILURE, TAG_ALL_ONES, 1'b1, 1'b0));
			send_event(make_event(MODE_RETRY, TAG_ALL_ONES, 1'b0, 1'b0));
		end
		// The attempt count now sits at the limit, so this retryable failure gives up.
		send_event(make_event(MODE_FAILURE, TAG_ALL_ONES, 1'b1, 1'b0));
		send_event(make_event(MODE_BEGIN, TAG_ALL_ONES, 1'b0, 1'b0));
		send_event(make_event(MODE_BEGIN, 32'd1, 1'b0, 1'b0));
		send_event(make_event(MODE_FAILURE, 32'd1, 1'b0, 1'b1));
		send_event(make_event(MODE_BEGIN, 32'd2, 1'b0, 1'b0));
		send_event(make_event(MODE_FAILURE, 32'd2, 1'b1, 1'b0));
		send_event(make_event(MODE_RETRY, 32'd2, 1'b0, 1'b0));
		send_event(make_event(MODE_COMPLETE, 32'd2, 1'b0, 1'b1));
		send_event(make_event(MODE_CANCEL, 32'd2, 1'b0, 1'b0));
		for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
			send_event(make_event(MODE_BITS'(m), 32'd2, 1'b1, 1'b1));
		send_event(make_event(MODE_RETRY, 32'd2, 1'b0, 1'b0));
		send_event(make_event(MODE_BEGIN, 32'd2, 1'b0, 1'b0));

		// Random part, one configuration per phase. Each change waits for the block
		// to drain first, which is also where the sender pauses for every result.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			success_pct = 40;
			idle_on = 1'b1;
			case (p)
				0: begin
					lim = '0;
					first = '0;
					ceiling = '0;
				end
				1: begin
					// Smallest nonzero settings: one retry, one millisecond throughout.
					lim = 8'd1;
					first = 20'd1;
					ceiling = 20'd1;
				end
				2: begin
					// Longest chains: the delay doubles from one up to the top of the
					// field, with no idling on either side.
					lim = 8'd255;
					first = 20'd1;
					ceiling = DELAY_ALL_ONES;
					success_pct = 3;
					idle_on = 1'b0;
				end
				3: begin
					// The ceiling register is at its default and below the first delay,
					// so the ceiling is raised to the first delay.
					lim = 8'd255;
					first = DELAY_ALL_ONES;
					ceiling = '0;
					success_pct = 10;
				end
				4: begin
					// Nonzero ceiling below the default first delay.
					lim = '0;
					first = '0;
					ceiling = 20'd100;
					idle_on = 1'b0;
				end
				5: begin
					lim = $urandom_range(1, 20);
					first = $urandom_range(1, 4000);
					ceiling = $urandom_range(0, 100000);
					success_pct = 15;
				end
				default: begin
					lim = $urandom_range(0, 255);
					first = $urandom;
					ceiling = $urandom;
					success_pct = 20;
				end
			endcase
			configure(lim, first, ceiling);
			// The hold-off starts only once events flow again, so the block fills up.
			if (p == HOLD_PHASE)
				hold_req = 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_event(next_session_event(success_pct));
		end

		settle_pipeline();
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
